// File: rtl/core/wem_pkg.sv
package wem_pkg;
  localparam int unsigned CfgWidth = 8;
  localparam int unsigned CfgIdxWidth = 2;
  localparam logic [CfgIdxWidth-1:0] RegWindowSize = 2'd0;
  localparam logic [CfgIdxWidth-1:0] RegMeanSpan = 2'd1;
  localparam logic [CfgIdxWidth-1:0] RegRateSpan = 2'd2;
  localparam logic [CfgWidth-1:0] WindowSizeReset = 8'd8;
  localparam logic [CfgWidth-1:0] MeanSpanReset = 8'd4;
  localparam logic [CfgWidth-1:0] RateSpanReset = 8'd4;
  localparam logic [17:0] RateScale = 18'd256000;

  typedef struct packed {
    logic signed [15:0] error_sample;
    logic [31:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] median_error;
    logic [3:0] sample_count;
    logic signed [15:0] smoothed_error;
    logic signed [31:0] rate_q8;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [63:0] quotient;
  } div_rsp_t;
endpackage

// File: rtl/core/wem_if.sv
interface wem_in_if;
  import wem_pkg::*;
  logic valid;
  logic ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface wem_out_if;
  import wem_pkg::*;
  logic valid;
  logic ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/windowed_error_median_rate.sv
// Processes one sample at a time and is not ready while working; the result
// is held in S_OUT through any output stall.
// The work is done by a shared serial divider (up to two divisions), a
// one-slot-per-cycle sorted insert, sign-count sweep and sum.
// Reset: registers take defaults 8/4/4 and the window is empty.
module windowed_error_median_rate
  import wem_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [CfgWidth-1:0] cfg_data_i,
  wem_in_if.sink in_if,
  wem_out_if.source out_if
);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_INS, S_CNT, S_POST, S_SUM, S_MDIV, S_MWAIT, S_RSET, S_RDIV, S_RWAIT, S_OUT
  } state_e;

  state_e state_q;
  logic [CfgWidth-1:0] wsize_q, mspan_q, rspan_q;
  logic signed [15:0] sorted_q [DEPTH];
  logic signed [15:0] arr_q [DEPTH];
  logic [31:0] tim_q [DEPTH];
  logic [CW-1:0] cnt_q, act, idx_q, n_q, w_q;
  logic signed [15:0] x_q, med_q;
  logic [CW-1:0] neg_q, posc_q;
  logic signed [23:0] sum_q;
  logic signed [47:0] prod_q;
  logic neg_res_q;
  logic [31:0] dur_q;
  out_item_t res_q;
  div_req_t dreq;
  div_rsp_t drsp;

  wem_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  always_comb begin
    if (wsize_q == '0) act = CW'(1);
    else if ({24'd0, wsize_q} < DEPTH) act = CW'(wsize_q);
    else act = CW'(DEPTH);
  end

  logic [CW-1:0] wm, wr;
  assign wm = ({24'd0, mspan_q} < 32'(cnt_q)) ? CW'(mspan_q) : cnt_q;
  assign wr = ({24'd0, rspan_q} < 32'(cnt_q)) ? CW'(rspan_q) : cnt_q;

  logic [63:0] q64;
  assign q64 = drsp.quotient;
  logic signed [15:0] mq;
  assign mq = neg_res_q ? -q64[15:0] : q64[15:0];
  logic signed [31:0] rq;
  always_comb begin
    if (neg_res_q) rq = (q64 > 64'h8000_0000) ? 32'sh8000_0000 : -q64[31:0];
    else rq = (q64 > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q64[31:0];
  end

  always_comb begin
    dreq = '0;
    if (state_q == S_MDIV) begin
      dreq.start = 1'b1;
      dreq.dividend = 64'(sum_q < 0 ? -sum_q : sum_q);
      dreq.divisor = 64'(w_q);
    end else if (state_q == S_RDIV) begin
      dreq.start = 1'b1;
      dreq.dividend = 64'(prod_q < 0 ? -prod_q : prod_q);
      dreq.divisor = 64'(dur_q);
    end
  end

  assign in_if.ready = (state_q == S_IDLE);
  assign out_if.valid = (state_q == S_OUT);
  assign out_if.data = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      wsize_q <= WindowSizeReset; mspan_q <= MeanSpanReset; rspan_q <= RateSpanReset;
      cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegWindowSize: wsize_q <= cfg_data_i;
          RegMeanSpan: mspan_q <= cfg_data_i;
          RegRateSpan: rspan_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: if (in_if.valid) begin
          x_q <= in_if.data.error_sample;
          if (cnt_q >= act) begin
            // clear: sorted region only grows from 0, so count is enough
            arr_q[0] <= in_if.data.error_sample; tim_q[0] <= in_if.data.time_ms;
            cnt_q <= '0; idx_q <= '0; n_q <= '0;
          end else begin
            arr_q[cnt_q[AW-1:0]] <= in_if.data.error_sample;
            tim_q[cnt_q[AW-1:0]] <= in_if.data.time_ms;
            idx_q <= cnt_q; n_q <= cnt_q;
          end
          state_q <= S_INS;
        end
        S_INS: begin
          // shift one slot up per cycle until the place is found
          if (idx_q != '0 && sorted_q[idx_q[AW-1:0] - AW'(1)] > x_q) begin
            sorted_q[idx_q[AW-1:0]] <= sorted_q[idx_q[AW-1:0] - AW'(1)];
            idx_q <= idx_q - CW'(1);
          end else begin
            sorted_q[idx_q[AW-1:0]] <= x_q;
            n_q <= n_q + CW'(1); idx_q <= '0;
            neg_q <= '0; posc_q <= '0;
            state_q <= S_CNT;
          end
        end
        S_CNT: begin
          if (sorted_q[idx_q[AW-1:0]] < 0) neg_q <= neg_q + CW'(1);
          else if (sorted_q[idx_q[AW-1:0]] > 0) posc_q <= posc_q + CW'(1);
          if (idx_q == n_q - CW'(1)) state_q <= S_POST;
          idx_q <= idx_q + CW'(1);
        end
        S_POST: begin
          med_q <= (neg_q == posc_q) ? 16'sd0 : sorted_q[AW'(n_q >> 1)];
          cnt_q <= (n_q >= act) ? '0 : n_q;
          sum_q <= '0;
          state_q <= S_SUM;
          idx_q <= '0;
        end
        S_SUM: begin
          if (cnt_q == '0 || wm == '0) begin
            res_q.smoothed_error <= '0; state_q <= S_RSET;
          end else if (idx_q == wm) begin
            w_q <= wm; neg_res_q <= sum_q < 0; state_q <= S_MDIV;
          end else begin
            sum_q <= sum_q + 24'(arr_q[AW'(cnt_q - CW'(1) - idx_q)]);
            idx_q <= idx_q + CW'(1);
          end
        end
        S_MDIV: state_q <= S_MWAIT;
        S_MWAIT: if (drsp.done) begin
          res_q.smoothed_error <= mq; state_q <= S_RSET;
        end
        S_RSET: begin
          res_q.median_error <= med_q;
          res_q.sample_count <= 4'(cnt_q);
          if (cnt_q < CW'(2) || rspan_q < 8'd2 ||
              tim_q[AW'(cnt_q - CW'(1))] <= tim_q[AW'(cnt_q - wr)]) begin
            res_q.rate_q8 <= '0; state_q <= S_OUT;
          end else begin
            dur_q <= tim_q[AW'(cnt_q - CW'(1))] - tim_q[AW'(cnt_q - wr)];
            prod_q <= 48'(17'sd0 - (17'(arr_q[AW'(cnt_q - CW'(1))])
                                    - 17'(arr_q[AW'(cnt_q - wr)])))
                      * $signed({1'b0, RateScale});
            state_q <= S_RDIV;
          end
        end
        S_RDIV: begin
          neg_res_q <= prod_q < 0; state_q <= S_RWAIT;
        end
        S_RWAIT: if (drsp.done) begin
          res_q.rate_q8 <= rq; state_q <= S_OUT;
        end
        S_OUT: if (out_if.ready) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/core/wem_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
module wem_div
  import wem_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);
  logic [6:0] cnt_q, cnt_d;
  logic [63:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [64:0] trial;

  always_comb begin
    cnt_d = cnt_q; rem_d = rem_q; quo_d = quo_q; den_d = den_q;
    busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q, quo_q[63]} - {1'b0, den_q};
    if (req_i.start) begin
      rem_d = '0; quo_d = req_i.dividend; den_d = req_i.divisor;
      cnt_d = 7'd64; busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_d = trial[63:0]; quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[62:0], quo_q[63]}; quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quotient = quo_q;
endmodule
